/* rtl/swgf_pkg.sv */
// package for the sobel weighted gradient filter: shared types, reset values,
// register indexes and the small arithmetic helpers of the gradient datapath.
// no dependencies.
package swgf_pkg;

   // default depth of the line store
   localparam int DEF_MAX_WIDTH = 2048;

   // result queue depth, a power of two
   localparam int RES_FIFO_DEPTH = 16;

   // register reset values
   localparam logic [11:0] RESET_IMAGE_WIDTH  = 12'd640;
   localparam logic [11:0] RESET_IMAGE_HEIGHT = 12'd480;
   localparam logic [15:0] RESET_WEIGHT_X     = 16'd256;
   localparam logic [15:0] RESET_WEIGHT_Y     = 16'd256;

   // register indexes of the csr port
   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_WEIGHT_X     = 2'd2,
      CSR_WEIGHT_Y     = 2'd3
   } csr_index_type;

   // one window column, rows top (0) to bottom (2)
   typedef logic [2:0][7:0] column_type;

   // control of a transaction after it left the input
   typedef struct packed {
      logic [7:0] pixel;
      logic       flush_phase;
      logic       row_is_one;
      logic       left_self;
      logic       has_a;
      logic       has_b;
      logic [1:0] n_res;
   } item_type;

   // absolute derivatives of both possible results
   typedef struct packed {
      logic [7:0] abs_ax;
      logic [7:0] abs_ay;
      logic [7:0] abs_bx;
      logic [7:0] abs_by;
      logic       has_a;
      logic       has_b;
      logic       eof_b;
      logic [1:0] n_res;
   } deriv_type;

   // weighted derivatives of both possible results
   typedef struct packed {
      logic [23:0] prod_ax;
      logic [23:0] prod_ay;
      logic [23:0] prod_bx;
      logic [23:0] prod_by;
      logic        has_a;
      logic        has_b;
      logic        eof_b;
      logic [1:0]  n_res;
   } product_type;

   // one entry of the result queue
   typedef struct packed {
      logic [7:0] gradient;
      logic       end_of_row;
      logic       end_of_frame;
      logic       last_of_run;
   } result_type;

   // |(b0 + 2*b1 + b2) - (a0 + 2*a1 + a2)| saturated to 255
   function automatic logic [7:0] grad_abs_sat(input logic [7:0] a0, input logic [7:0] a1,
                                               input logic [7:0] a2, input logic [7:0] b0,
                                               input logic [7:0] b1, input logic [7:0] b2);
      logic [9:0] sum_a;
      logic [9:0] sum_b;
      logic [9:0] diff;
      sum_a = 10'(a0) + {1'b0, a1, 1'b0} + 10'(a2);
      sum_b = 10'(b0) + {1'b0, b1, 1'b0} + 10'(b2);
      diff  = (sum_b >= sum_a) ? (sum_b - sum_a) : (sum_a - sum_b);
      return (diff > 10'd255) ? 8'hFF : diff[7:0];
   endfunction

   // (a + b + 128) >> 8 saturated to 255
   function automatic logic [7:0] round_sat(input logic [23:0] a, input logic [23:0] b);
      logic [24:0] total;
      total = 25'(a) + 25'(b) + 25'd128;
      return (total[24:16] != 9'd0) ? 8'hFF : total[15:8];
   endfunction

endpackage

/* rtl/sobel_weighted_gradient_filter.sv */
// streaming 3x3 sobel filter with weighted l1 gradient magnitude, top level.
// depends on swgf_pkg for types, reset values and the gradient helpers.
//
// usage: gray pixels enter in raster order on the req_ channel, one transaction
// per pixel; the rsp_ channel returns the filtered image one row and one column
// behind. borders are mirrored without repeating the edge pixel. after the last
// pixel of a frame, image_width transactions with req_flush set push out the
// final row; a flush inside a frame is dropped without effect.
// a transaction is taken in every cycle that req_stall is low. the accepting
// edge loads the input register and reads the line store; window and
// derivatives, weight multiply and rounding into the result queue follow, and
// rsp_valid rises with the queued result. the last-column transaction of a row
// gives two results and the first column none, so one row of pixels gives one
// row of results; the single result port sets the sustained rate, one per cycle.
// when the receiver stalls, results collect in a 16-entry queue; req_stall
// rises once the queue plus the results still in the pipeline could fill it.
// synchronous reset clears the counters, window, queue and registers to their
// defaults; the line store is not cleared and needs no clearing pass.
// csr writes are always ready and are meant for idle time between frames.
module sobel_weighted_gradient_filter
   import swgf_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic        req_flush,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_gradient,
   output logic        rsp_end_of_row,
   output logic        rsp_end_of_frame,
   output logic        rsp_last_of_run,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int FIFO_AW = $clog2(RES_FIFO_DEPTH);

   // configuration registers
   logic [11:0] image_width_ff;
   logic [11:0] image_height_ff;
   logic [15:0] weight_x_ff;
   logic [15:0] weight_y_ff;

   // position counters
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [11:0]      row_count_ff, row_count_in;

   // effective geometry
   logic [COL_W:0]   width_eff;
   logic [COL_W:0]   width_m1;
   logic [COL_W-1:0] last_col;
   logic [11:0]      height_eff;

   // input decode
   logic     accept;
   logic     take;
   logic     flush_phase;
   logic     col_last;
   logic     row_nonzero;
   item_type item_in;

   // line store and its read register, {upper, lower}
   logic [15:0] line_mem_ff [MAX_WIDTH];
   logic [15:0] line_rd_ff;

   // stage registers
   logic             st1_valid_ff;
   item_type         st1_ff;
   logic [COL_W-1:0] st1_col_ff;
   logic             st2_valid_ff;
   deriv_type        st2_ff;
   logic             st3_valid_ff;
   product_type      st3_ff;

   // window
   column_type win_ff [3];
   column_type win_in [3];
   column_type col_new;
   column_type left_a;
   deriv_type  deriv_in;
   logic [7:0] line_up;
   logic [7:0] line_lo;

   // result queue
   result_type         fifo_ff [RES_FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   fifo_count_ff, fifo_count_in;
   logic [FIFO_AW+1:0] reserve;
   result_type         res_a;
   result_type         res_b;
   logic               push0;
   logic               push1;
   logic               pop;

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
         weight_x_ff     <= RESET_WEIGHT_X;
         weight_y_ff     <= RESET_WEIGHT_Y;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[11:0];
            CSR_WEIGHT_X:     weight_x_ff     <= csr_wdata;
            CSR_WEIGHT_Y:     weight_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp width to 2..MAX_WIDTH and height to at least 2
   always_comb begin
      if (image_width_ff < 12'd2) begin
         width_eff = (COL_W+1)'(2);
      end else if (image_width_ff > MAX_WIDTH) begin
         width_eff = (COL_W+1)'(MAX_WIDTH);
      end else begin
         width_eff = (COL_W+1)'(image_width_ff);
      end
      width_m1   = width_eff - (COL_W+1)'(1);
      last_col   = width_m1[COL_W-1:0];
      height_eff = (image_height_ff < 12'd2) ? 12'd2 : image_height_ff;
   end

   // input decode and position update
   assign accept      = req_valid && !req_stall;
   assign flush_phase = row_count_ff >= height_eff;
   assign take        = accept && (flush_phase || !req_flush);
   assign col_last    = column_count_ff >= last_col;
   assign row_nonzero = row_count_ff != 12'd0;

   always_comb begin
      item_in.pixel       = req_pixel;
      item_in.flush_phase = flush_phase;
      item_in.row_is_one  = row_count_ff == 12'd1;
      item_in.left_self   = column_count_ff == COL_W'(1);
      item_in.has_a       = row_nonzero && (column_count_ff != '0);
      item_in.has_b       = row_nonzero && col_last;
      item_in.n_res       = {1'b0, item_in.has_a} + {1'b0, item_in.has_b};

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (take) begin
         if (col_last) begin
            column_count_in = '0;
            row_count_in    = flush_phase ? 12'd0 : row_count_ff + 12'd1;
         end else begin
            column_count_in = column_count_ff + COL_W'(1);
         end
      end
   end

   // line store: read at acceptance, shift rows in the following cycle
   always_ff @(posedge clock) begin
      if (take) begin
         line_rd_ff <= line_mem_ff[column_count_ff];
      end
      if (st1_valid_ff && !st1_ff.flush_phase) begin
         line_mem_ff[st1_col_ff] <= {line_lo, st1_ff.pixel};
      end
   end

   // new window column, mirrored at the top and bottom borders
   assign line_up = line_rd_ff[15:8];
   assign line_lo = line_rd_ff[7:0];

   always_comb begin
      if (st1_ff.flush_phase) begin
         col_new[0] = line_up;
         col_new[2] = line_up;
      end else begin
         col_new[0] = st1_ff.row_is_one ? st1_ff.pixel : line_up;
         col_new[2] = st1_ff.pixel;
      end
      col_new[1] = line_lo;

      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = col_new;
   end

   // derivatives; left column mirrors at column 1, right column at the last
   always_comb begin
      left_a = st1_ff.left_self ? win_in[2] : win_in[0];
      deriv_in.abs_ax = grad_abs_sat(left_a[0], left_a[1], left_a[2],
                                     win_in[2][0], win_in[2][1], win_in[2][2]);
      deriv_in.abs_ay = grad_abs_sat(left_a[0], win_in[1][0], win_in[2][0],
                                     left_a[2], win_in[1][2], win_in[2][2]);
      deriv_in.abs_bx = grad_abs_sat(win_in[1][0], win_in[1][1], win_in[1][2],
                                     win_in[1][0], win_in[1][1], win_in[1][2]);
      deriv_in.abs_by = grad_abs_sat(win_in[1][0], win_in[2][0], win_in[1][0],
                                     win_in[1][2], win_in[2][2], win_in[1][2]);
      deriv_in.has_a  = st1_ff.has_a;
      deriv_in.has_b  = st1_ff.has_b;
      deriv_in.eof_b  = st1_ff.flush_phase;
      deriv_in.n_res  = st1_ff.n_res;
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (take) begin
         st1_ff     <= item_in;
         st1_col_ff <= column_count_ff;
      end
      st2_ff                <= deriv_in;
      st3_ff.prod_ax        <= 24'(weight_x_ff) * 24'(st2_ff.abs_ax);
      st3_ff.prod_ay        <= 24'(weight_y_ff) * 24'(st2_ff.abs_ay);
      st3_ff.prod_bx        <= 24'(weight_x_ff) * 24'(st2_ff.abs_bx);
      st3_ff.prod_by        <= 24'(weight_y_ff) * 24'(st2_ff.abs_by);
      st3_ff.has_a          <= st2_ff.has_a;
      st3_ff.has_b          <= st2_ff.has_b;
      st3_ff.eof_b          <= st2_ff.eof_b;
      st3_ff.n_res          <= st2_ff.n_res;
   end

   // rounding and result formation
   always_comb begin
      res_a.gradient     = round_sat(st3_ff.prod_ax, st3_ff.prod_ay);
      res_a.end_of_row   = 1'b0;
      res_a.end_of_frame = 1'b0;
      res_a.last_of_run  = !st3_ff.has_b;
      res_b.gradient     = round_sat(st3_ff.prod_bx, st3_ff.prod_by);
      res_b.end_of_row   = 1'b1;
      res_b.end_of_frame = st3_ff.eof_b;
      res_b.last_of_run  = 1'b1;
   end

   // result queue control
   assign push0 = st3_valid_ff && (st3_ff.has_a || st3_ff.has_b);
   assign push1 = st3_valid_ff && st3_ff.has_a && st3_ff.has_b;
   assign pop   = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in     = wr_ptr_ff + FIFO_AW'(push0) + FIFO_AW'(push1);
      rd_ptr_in     = rd_ptr_ff + FIFO_AW'(pop);
      fifo_count_in = fifo_count_ff + (FIFO_AW+1)'(push0) + (FIFO_AW+1)'(push1)
                      - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= st3_ff.has_a ? res_a : res_b;
      end
      if (push1) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= res_b;
      end
   end

   // queue entries plus results still in flight
   always_comb begin
      reserve = (FIFO_AW+2)'(fifo_count_ff)
              + (FIFO_AW+2)'(st1_valid_ff ? st1_ff.n_res : 2'd0)
              + (FIFO_AW+2)'(st2_valid_ff ? st2_ff.n_res : 2'd0)
              + (FIFO_AW+2)'(st3_valid_ff ? st3_ff.n_res : 2'd0);
   end

   assign req_stall = reserve > (FIFO_AW+2)'(RES_FIFO_DEPTH - 2);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         st1_valid_ff    <= 1'b0;
         st2_valid_ff    <= 1'b0;
         st3_valid_ff    <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fifo_count_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         st1_valid_ff    <= take;
         st2_valid_ff    <= st1_valid_ff;
         st3_valid_ff    <= st2_valid_ff;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         fifo_count_ff   <= fifo_count_in;
         if (st1_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
      end
   end

   // output from the queue head
   assign rsp_valid        = fifo_count_ff != '0;
   assign rsp_gradient     = fifo_ff[rd_ptr_ff].gradient;
   assign rsp_end_of_row   = fifo_ff[rd_ptr_ff].end_of_row;
   assign rsp_end_of_frame = fifo_ff[rd_ptr_ff].end_of_frame;
   assign rsp_last_of_run  = fifo_ff[rd_ptr_ff].last_of_run;

   // checks
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= (FIFO_AW+1)'(RES_FIFO_DEPTH))
      else $error("result queue count above depth");

   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserve <= (FIFO_AW+2)'(RES_FIFO_DEPTH))
      else $error("results in flight exceed queue room");

   a_eof_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_row && rsp_last_of_run)
      else $error("end of frame without end of row");

   a_flush_in_frame: assert property (@(posedge clock) disable iff (reset)
      accept && req_flush && !flush_phase
      |=> $stable(column_count_ff) && $stable(row_count_ff))
      else $error("flush inside a frame moved the position");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      take && col_last && flush_phase |=> row_count_ff == 12'd0 && column_count_ff == '0)
      else $error("final flush did not restart the frame");

endmodule
